>>> design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/cfc_pkg.sv
package cfc_pkg;

    localparam logic [7:0] CRC_POLY    = 8'h07;
    localparam logic [7:0] CRC_INIT    = 8'h00;
    localparam logic [2:0] MAX_BYTES   = 3'd5;
    localparam logic [2:0] READ_LEN    = 3'd4;
    localparam logic [2:0] HEADER_LAST = 3'd2;
    localparam logic [2:0] COUNT_MAX   = 3'd7;
    localparam int         FRAME_DEPTH = 5;

    localparam logic [7:0] FC_READ_A  = 8'd1;
    localparam logic [7:0] FC_READ_B  = 8'd3;
    localparam logic [7:0] FC_WRITE_A = 8'd5;
    localparam logic [7:0] FC_WRITE_B = 8'd6;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_MALFORMED = 3'd1,
        ST_TOO_MANY  = 3'd2,
        ST_TOO_FEW   = 3'd3,
        ST_BAD_FUNC  = 3'd4,
        ST_READ_LEN  = 3'd5,
        ST_WRITE_LEN = 3'd6
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       malformed;
        logic       last_byte;
    } item_t;

    // last field in the lowest bits
    typedef struct packed {
        logic       crc_ok;
        logic [7:0] computed_crc;
        logic [7:0] received_crc;
        logic [7:0] write_value;
        logic [7:0] cell_address;
        logic [7:0] function_code;
        logic [7:0] device_address;
        logic       is_write;
        logic [2:0] frame_status;
    } result_t;

    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

>>> design/cfc_in_stage.sv
module cfc_in_stage (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  cfc_pkg::item_t s_item,
    input  logic           take,
    output logic           item_valid,
    output cfc_pkg::item_t item
);
    import cfc_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign s_tready   = !valid_reg || take;
    assign valid_next = s_tready ? s_tvalid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

>>> design/cfc_frame_core.sv
module cfc_frame_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             item_valid,
    input  cfc_pkg::item_t   item,
    output logic             take,
    output logic             m_tvalid,
    input  logic             m_tready,
    output cfc_pkg::result_t result
);
    import cfc_pkg::*;

    logic [2:0] byte_count_reg;
    logic [2:0] byte_count_next;
    logic [7:0] frame_reg [FRAME_DEPTH];
    logic [7:0] frame_next [FRAME_DEPTH];
    logic [7:0] crc_run_reg;
    logic [7:0] crc_run_next;
    logic [7:0] crc_three_reg;
    logic [7:0] crc_three_next;
    logic       bad_seen_reg;
    logic       bad_seen_next;
    logic       ovf_seen_reg;
    logic       ovf_seen_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    result_t    result_reg;

    logic [7:0] b_eff;
    logic       in_range;
    logic [7:0] byte_cur [FRAME_DEPTH];
    logic [7:0] crc_cur;
    logic [7:0] crc3_cur;
    logic [2:0] count_cur;
    logic       bad_cur;
    logic       ovf_cur;
    logic       rd;
    logic       wr;
    status_t    status;
    result_t    res_cur;
    logic       emit;

    assign take = item_valid && (!item.last_byte || !out_valid_reg || m_tready);
    assign emit = take && item.last_byte;

    always_comb begin
        b_eff    = item.malformed ? 8'h00 : item.data_byte;
        in_range = byte_count_reg < MAX_BYTES;
        for (int k = 0; k < FRAME_DEPTH; k++) begin
            byte_cur[k] = (in_range && byte_count_reg == 3'(k)) ? b_eff : frame_reg[k];
        end
        crc_cur   = (byte_count_reg < READ_LEN) ? crc8_step(crc_run_reg, b_eff) : crc_run_reg;
        crc3_cur  = (byte_count_reg == HEADER_LAST) ? crc_cur : crc_three_reg;
        count_cur = (byte_count_reg == COUNT_MAX) ? byte_count_reg : byte_count_reg + 3'd1;
        bad_cur   = bad_seen_reg || item.malformed;
        ovf_cur   = ovf_seen_reg || !in_range;

        rd = (byte_cur[1] == FC_READ_A) || (byte_cur[1] == FC_READ_B);
        wr = (byte_cur[1] == FC_WRITE_A) || (byte_cur[1] == FC_WRITE_B);

        if (bad_cur) begin
            status = ST_MALFORMED;
        end else if (ovf_cur || count_cur > MAX_BYTES) begin
            status = ST_TOO_MANY;
        end else if (count_cur <= 3'd1) begin
            status = ST_TOO_FEW;
        end else if (!rd && !wr) begin
            status = ST_BAD_FUNC;
        end else if (rd && count_cur != READ_LEN) begin
            status = ST_READ_LEN;
        end else if (wr && count_cur != MAX_BYTES) begin
            status = ST_WRITE_LEN;
        end else begin
            status = ST_OK;
        end

        res_cur.frame_status   = status;
        res_cur.is_write       = wr;
        res_cur.device_address = byte_cur[0];
        res_cur.function_code  = byte_cur[1];
        res_cur.cell_address   = byte_cur[2];
        res_cur.write_value    = wr ? byte_cur[3] : 8'h00;
        res_cur.received_crc   = wr ? byte_cur[4] : byte_cur[3];
        res_cur.computed_crc   = wr ? crc_cur : crc3_cur;
        res_cur.crc_ok         = (res_cur.received_crc == res_cur.computed_crc);
    end

    always_comb begin
        byte_count_next = byte_count_reg;
        frame_next      = frame_reg;
        crc_run_next    = crc_run_reg;
        crc_three_next  = crc_three_reg;
        bad_seen_next   = bad_seen_reg;
        ovf_seen_next   = ovf_seen_reg;
        if (take) begin
            if (item.last_byte) begin
                byte_count_next = 3'd0;
                for (int k = 0; k < FRAME_DEPTH; k++) begin
                    frame_next[k] = 8'h00;
                end
                crc_run_next   = CRC_INIT;
                crc_three_next = CRC_INIT;
                bad_seen_next  = 1'b0;
                ovf_seen_next  = 1'b0;
            end else begin
                byte_count_next = count_cur;
                frame_next      = byte_cur;
                crc_run_next    = crc_cur;
                crc_three_next  = crc3_cur;
                bad_seen_next   = bad_cur;
                ovf_seen_next   = ovf_cur;
            end
        end
        out_valid_next = emit || (out_valid_reg && !m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg <= 3'd0;
            for (int k = 0; k < FRAME_DEPTH; k++) begin
                frame_reg[k] <= 8'h00;
            end
            crc_run_reg   <= CRC_INIT;
            crc_three_reg <= CRC_INIT;
            bad_seen_reg  <= 1'b0;
            ovf_seen_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            byte_count_reg <= byte_count_next;
            frame_reg      <= frame_next;
            crc_run_reg    <= crc_run_next;
            crc_three_reg  <= crc_three_next;
            bad_seen_reg   <= bad_seen_next;
            ovf_seen_reg   <= ovf_seen_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            result_reg <= res_cur;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign result   = result_reg;

endmodule

>>> design/command_frame_checker_crc8.sv
// channel   dir  tdata                         tuser      tlast
// s_        in   data_byte[7:0]                malformed  last_byte
// m_        out  status..crc_ok, 53 bits in 56 -          -
//
// one byte per cycle sustained unless a held result stalls a last byte; a byte
// waits in the input register, the frame state and crc step update at the edge
// it leaves, and the frame result lands in the output register at that same
// edge, where m_tvalid is registered and rises. aresetn is synchronous and clears
// the frame state and both valid flags. a held result stalls only a last
// byte; other bytes keep flowing while m_tready is low
module command_frame_checker_crc8 (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte[7:0]
    input  logic [0:0]  s_tuser,   // malformed[0]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    // frame_status[2:0] is_write[3] device_address[11:4] function_code[19:12]
    // cell_address[27:20] write_value[35:28] received_crc[43:36]
    // computed_crc[51:44] crc_ok[52] zero[55:53]
    output logic [55:0] m_tdata
);
    import cfc_pkg::*;

    item_t   s_item;
    item_t   item;
    logic    item_valid;
    logic    take;
    result_t result;

    assign s_item.data_byte = s_tdata;
    assign s_item.malformed = s_tuser[0];
    assign s_item.last_byte = s_tlast;

    cfc_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    cfc_frame_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item       (item),
        .take       (take),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .result     (result)
    );

    assign m_tdata = {3'b000, result};

endmodule

>>> design/cfc_checker.sv
`include "assert_macros.svh"

module cfc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata
);
    import cfc_pkg::*;

    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped or changed while stalled")
    `ASSERT_SAME(a_crc_ok, aclk, aresetn, m_tvalid, m_tdata[52] == (m_tdata[43:36] == m_tdata[51:44]), "crc_ok disagrees with crc fields")
    `ASSERT_SAME(a_read_wval, aclk, aresetn, m_tvalid && !m_tdata[3], m_tdata[35:28] == 8'h00, "write value nonzero on read layout")
    `ASSERT_SAME(a_ok_func, aclk, aresetn, m_tvalid && m_tdata[2:0] == ST_OK, m_tdata[19:12] == FC_READ_A || m_tdata[19:12] == FC_READ_B || m_tdata[19:12] == FC_WRITE_A || m_tdata[19:12] == FC_WRITE_B, "ok status with unknown function")
    `ASSERT_SAME(a_status_range, aclk, aresetn, m_tvalid, m_tdata[2:0] != 3'd7 && m_tdata[55:53] == 3'b000, "bad status code or padding")

endmodule

bind command_frame_checker_crc8 cfc_checker u_cfc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
